### sv/cms_pkg.sv
// shared types and constants for the can message segmenter
// no dependencies; imported by all segmenter modules
package cms_pkg;

    localparam int FRAME_BYTES_DEF = 8;

    localparam int BYTE_W    = 8;
    localparam int STATION_W = 7;
    localparam int SEG_W     = 8;
    localparam int POS_W     = 2;
    localparam int LEN_W     = 4;
    localparam int PAYLOAD_W = 64;
    localparam int SRC_W     = 8;
    localparam int FUNC_W    = 4;
    localparam int ID_W      = 29;
    localparam int CFG_IDX_W = 1;

    // segment position codes
    localparam logic [POS_W-1:0] POS_NONE   = 2'd0;
    localparam logic [POS_W-1:0] POS_FIRST  = 2'd1;
    localparam logic [POS_W-1:0] POS_MIDDLE = 2'd2;
    localparam logic [POS_W-1:0] POS_FINAL  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ID     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_CODE = 1'b1;

    // finished frame as handed from front to back
    typedef struct packed {
        logic [STATION_W-1:0] station;
        logic [POS_W-1:0]     pos;
        logic [SEG_W-1:0]     seg;
        logic [LEN_W-1:0]     len;
        logic [PAYLOAD_W-1:0] payload;
        logic                 eom;
    } t_frame_rec;

endpackage

### sv/cms_front.sv
// front end: takes payload bytes, assembles frames, classifies position
// depends on cms_pkg
module cms_front import cms_pkg::*; #(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic                 i_last,
    input  logic [STATION_W-1:0] i_dest,
    input  logic                 i_full,
    output logic                 o_push,
    output t_frame_rec           o_rec
);

    localparam int CHUNK_W = FRAME_BYTES * BYTE_W;

    logic [CHUNK_W-1:0]   r_chunk, n_chunk;
    logic [LEN_W-1:0]     r_fill, n_fill;
    logic                 r_first, n_first;
    logic [SEG_W-1:0]     r_seg, n_seg;
    logic [STATION_W-1:0] r_station, n_station;

    logic             accept;
    logic [LEN_W-1:0] fill_inc;
    logic [CHUNK_W-1:0] chunk_ins;
    logic             frame_full;
    logic             emit;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign fill_inc = r_fill + LEN_W'(1);
    assign frame_full = (fill_inc == LEN_W'(FRAME_BYTES));
    assign emit = accept && (i_last || frame_full);

    always_comb begin
        chunk_ins = r_chunk;
        for (int k = 0; k < FRAME_BYTES; k++) begin
            if (r_fill == LEN_W'(k)) begin
                chunk_ins[k*BYTE_W +: BYTE_W] = i_data_byte;
            end
        end
    end

    always_comb begin
        n_chunk   = r_chunk;
        n_fill    = r_fill;
        n_first   = r_first;
        n_seg     = r_seg;
        n_station = r_station;
        if (accept) begin
            if (r_first && (r_fill == '0)) begin
                n_station = i_dest;
            end
            n_chunk = chunk_ins;
            n_fill  = fill_inc;
            if (emit) begin
                n_chunk = '0;
                n_fill  = '0;
            end
            if (i_last) begin
                n_first = 1'b1;
                n_seg   = '0;
            end else if (frame_full) begin
                n_first = 1'b0;
                n_seg   = r_first ? SEG_W'(1) : r_seg + SEG_W'(1);
            end
        end
    end

    always_comb begin
        o_push          = emit;
        o_rec.station   = (r_first && (r_fill == '0)) ? i_dest : r_station;
        o_rec.seg       = r_first ? '0 : r_seg;
        o_rec.len       = fill_inc;
        o_rec.payload   = PAYLOAD_W'(chunk_ins);
        o_rec.eom       = i_last;
        if (i_last) begin
            o_rec.pos = r_first ? POS_NONE : POS_FINAL;
        end else begin
            o_rec.pos = r_first ? POS_FIRST : POS_MIDDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk   <= '0;
            r_fill    <= '0;
            r_first   <= 1'b1;
            r_seg     <= '0;
            r_station <= '0;
        end else begin
            r_chunk   <= n_chunk;
            r_fill    <= n_fill;
            r_first   <= n_first;
            r_seg     <= n_seg;
            r_station <= n_station;
        end
    end

endmodule

### sv/cms_queue.sv
// two-entry frame queue between front and back
// depends on cms_pkg
module cms_queue import cms_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_rec i_rec,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_valid,
    output t_frame_rec o_rec
);

    t_frame_rec r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

endmodule

### sv/cms_back.sv
// back end: config registers, identifier build and output register
// depends on cms_pkg
module cms_back import cms_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SRC_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    input  t_frame_rec           i_rec,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [ID_W-1:0]      o_ext_identifier,
    output logic [LEN_W-1:0]     o_frame_length,
    output logic [PAYLOAD_W-1:0] o_frame_payload,
    output logic                 o_end_of_message
);

    logic [SRC_W-1:0]  r_src;
    logic [FUNC_W-1:0] r_func;
    logic              r_valid;

    assign o_pop   = i_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src  <= SRC_W'(1);
            r_func <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SOURCE_ID:     r_src  <= i_cfg_data;
                CFG_FUNCTION_CODE: r_func <= i_cfg_data[FUNC_W-1:0];
                default:           r_src  <= r_src;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // dest | position | segment | function | source
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_ext_identifier <= {i_rec.station, i_rec.pos, i_rec.seg, r_func, r_src};
            o_frame_length   <= i_rec.len;
            o_frame_payload  <= i_rec.payload;
            o_end_of_message <= i_rec.eom;
        end
    end

endmodule

### sv/can_message_segmenter_unit.sv
// top level of the can message segmenter
// depends on cms_pkg, cms_front, cms_queue, cms_back
//
// Splits a byte stream into CAN extended data frames of up to FRAME_BYTES payload
// bytes. One byte is taken per transaction on the slave side, tlast marking the
// final byte of a message; the destination is sampled on the first byte. A message
// that fits one frame leaves as one unsegmented frame; longer messages leave as
// first, middle and final frames with an 8-bit wrapping segment number. The
// identifier is {dest[28:22], position[21:20], segment[19:12], function[11:8],
// source[7:0]} with positions none 0, first 1, middle 2, final 3. Throughput is
// one byte per clock with a result at most every clock: the front adds each byte
// to a frame as it is accepted, a two-entry frame queue sits between it and the
// output register, and the slave side stalls only while that queue is full.
// A frame closed by a byte is written into the queue and then into the output
// register before it is offered on the master side. Configuration writes are
// always accepted and must be issued only while no message is in flight.
module can_message_segmenter_unit import cms_pkg::*; #(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SRC_W-1:0]     i_cfg_data,
    // byte input
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,  // data_byte[7:0], dest_station[14:8], zero
    input  logic                 s_axis_tlast,  // last_byte
    // frame output
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [103:0]         m_axis_tdata,  // ext_identifier[28:0], frame_length[32:29],
                                                // frame_payload[96:33], zero
    output logic                 m_axis_tlast   // end_of_message
);

    // front to queue
    logic       push;
    t_frame_rec push_rec;
    logic       q_full;

    // queue to back
    logic       q_valid;
    logic       pop;
    t_frame_rec pop_rec;

    // back outputs
    logic [ID_W-1:0]      ext_identifier;
    logic [LEN_W-1:0]     frame_length;
    logic [PAYLOAD_W-1:0] frame_payload;

    // config registers have no busy condition
    assign o_cfg_ready = 1'b1;

    cms_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data_byte (s_axis_tdata[7:0]),
        .i_last      (s_axis_tlast),
        .i_dest      (s_axis_tdata[14:8]),
        .i_full      (q_full),
        .o_push      (push),
        .o_rec       (push_rec)
    );

    cms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rec   (pop_rec)
    );

    cms_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (q_valid),
        .i_rec            (pop_rec),
        .o_pop            (pop),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_ext_identifier (ext_identifier),
        .o_frame_length   (frame_length),
        .o_frame_payload  (frame_payload),
        .o_end_of_message (m_axis_tlast)
    );

    // pack output fields, lowest first, padded to whole bytes
    assign m_axis_tdata = {7'b0, frame_payload, frame_length, ext_identifier};

endmodule

### bench/tb_can_message_segmenter_unit.sv
// self-checking bench for can_message_segmenter_unit: byte stream in, CAN frames out
// depends on cms_pkg for widths, position codes and register indexes
// frames are predicted per accepted byte and checked in order against the master side
module tb_can_message_segmenter_unit;
    import cms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
    localparam int HOLD_LEN       = 300;   // long master-side hold to back up the input
    localparam int DRAIN_CYCLES   = 16;    // settle time after the last frame of a phase
    localparam int REPORT_MAX     = 10;

    // one byte of a message as offered on the slave side
    typedef struct packed {
        logic [BYTE_W-1:0]    data;
        logic                 last;
        logic [STATION_W-1:0] dest;
    } t_msg_byte;

    // one frame as it leaves on the master side
    typedef struct packed {
        logic [ID_W-1:0]      ext_id;
        logic [LEN_W-1:0]     len;
        logic [PAYLOAD_W-1:0] payload;
        logic                 eom;
    } t_can_frame;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [SRC_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [103:0]         m_axis_tdata;
    logic                 m_axis_tlast;

    can_message_segmenter_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // transactions seen at the current edge
    wire byte_xfer  = s_axis_tvalid && s_axis_tready;
    wire frame_xfer = m_axis_tvalid && m_axis_tready;
    wire cfg_xfer   = i_cfg_valid && o_cfg_ready;

    // bytes waiting to be offered, frames waiting to come out
    t_msg_byte  bytes_pending[$];
    t_can_frame frames_due[$];

    // register copies, reset values of the block
    logic [SRC_W-1:0]  src_id    = 8'd1;
    logic [FUNC_W-1:0] func_code = '0;

    // frame assembly state mirrored from the block
    logic [PAYLOAD_W-1:0] asm_bytes;
    logic [LEN_W-1:0]     asm_fill;
    logic                 asm_first;
    logic [SEG_W-1:0]     next_seg;
    logic [STATION_W-1:0] msg_station;

    // stimulus shaping
    bit quiet      = 1'b0;   // no idling on either side
    bit hold_start = 1'b0;   // ask the sink for one long hold
    bit hold_done  = 1'b0;
    int hold_count = 0;
    int src_gap    = 0;
    int sink_gap   = 0;

    int mismatches   = 0;
    int bytes_taken  = 0;
    int frames_seen  = 0;
    int msgs_queued  = 0;
    int settings     = 1;
    int stall_cycles = 0;

    // add one byte to the frame under assembly; returns 1 when a frame is closed
    function automatic bit frame_from_byte(input t_msg_byte b, output t_can_frame f);
        bit               closed;
        logic [POS_W-1:0] pos;
        logic [SEG_W-1:0] seg;
        closed = 1'b0;
        pos    = POS_NONE;
        seg    = '0;
        f      = '0;
        // a fill left at full size would start over
        if (asm_fill >= FRAME_BYTES_DEF) begin
            asm_bytes = '0;
            asm_fill  = '0;
        end
        // destination is latched on the first byte of a message only
        if (asm_first && asm_fill == 0)
            msg_station = b.dest;
        asm_bytes[8*asm_fill +: 8] = b.data;
        asm_fill = asm_fill + 1'b1;
        if (b.last) begin
            closed = 1'b1;
            if (asm_first) begin
                pos = POS_NONE;
            end else begin
                pos = POS_FINAL;
                seg = next_seg;
            end
            asm_first = 1'b1;
            next_seg  = '0;
        end else if (asm_fill >= FRAME_BYTES_DEF) begin
            // a full frame with more to come goes out right away
            closed = 1'b1;
            if (asm_first) begin
                pos       = POS_FIRST;
                asm_first = 1'b0;
                next_seg  = 8'd1;
            end else begin
                pos      = POS_MIDDLE;
                seg      = next_seg;
                next_seg = next_seg + 1'b1;  // wraps at 8 bits
            end
        end
        if (closed) begin
            f.ext_id  = {msg_station, pos, seg, func_code, src_id};
            f.len     = asm_fill;
            f.payload = asm_bytes;
            f.eom     = b.last;
            asm_bytes = '0;
            asm_fill  = '0;
        end
        return closed;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("frame %0d: %s expected %h, got %h", frames_seen, name, want, got);
        end
    endfunction

    // byte driver: predicts on every accepted byte, then offers the next one
    always @(posedge i_clk) begin : drive_bytes
        t_can_frame fr;
        t_msg_byte  nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap     = 0;
            asm_bytes   = '0;
            asm_fill    = '0;
            asm_first   = 1'b1;
            next_seg    = '0;
            msg_station = '0;
        end else begin
            if (byte_xfer) begin
                if (frame_from_byte({s_axis_tdata[7:0], s_axis_tlast, s_axis_tdata[14:8]}, fr))
                    frames_due.push_back(fr);
                bytes_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (!quiet && bytes_pending.size() > 0 && $urandom_range(0, 7) == 0) begin
                    // idle burst of random length
                    src_gap = $urandom_range(0, 7);
                    s_axis_tvalid <= 1'b0;
                end else if (bytes_pending.size() > 0) begin
                    nxt = bytes_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {1'b0, nxt.dest, nxt.data};
                    s_axis_tlast  <= nxt.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink ready: random stall bursts plus one long hold when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end else if (hold_start && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_count++;
            if (hold_count >= HOLD_LEN)
                hold_done = 1'b1;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            sink_gap = $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // frame monitor: every frame transaction is matched against the oldest prediction
    always @(posedge i_clk) begin : check_frames
        t_can_frame want;
        if (i_rst_n && frame_xfer) begin
            if (frames_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected frame: id %h tdata %h", m_axis_tdata[28:0], m_axis_tdata);
            end else begin
                want = frames_due.pop_front();
                check_field("ext_identifier", 64'(want.ext_id), 64'(m_axis_tdata[28:0]));
                check_field("frame_length", 64'(want.len), 64'(m_axis_tdata[32:29]));
                check_field("frame_payload", want.payload, m_axis_tdata[96:33]);
                check_field("end_of_message", 64'(want.eom), 64'(m_axis_tlast));
                frames_seen++;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (byte_xfer || frame_xfer || cfg_xfer)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d frames outstanding",
                         stall_cycles, frames_due.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SRC_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SOURCE_ID)
            src_id = val;
        else
            func_code = val[FUNC_W-1:0];
    endtask

    task automatic add_byte(input logic [7:0] data, input logic last, input logic [6:0] dest);
        t_msg_byte b;
        b.data = data;
        b.last = last;
        b.dest = dest;
        bytes_pending.push_back(b);
    endtask

    // well-formed message with random content; dest changes per byte to test the latch
    task automatic add_message(input int n_bytes);
        for (int i = 0; i < n_bytes; i++)
            add_byte(8'($urandom_range(0, 255)), i == n_bytes - 1, 7'($urandom_range(0, 127)));
        msgs_queued++;
    endtask

    // random messages, lengths biased around frame boundaries
    task automatic add_messages(input int n_bytes);
        int queued;
        int r;
        queued = 0;
        while (queued < n_bytes) begin
            r = $urandom_range(0, 9);
            if (r < 4)
                r = $urandom_range(1, 8);
            else if (r == 4)
                r = 8 * $urandom_range(1, 5);
            else if (r < 9)
                r = $urandom_range(9, 40);
            else
                r = $urandom_range(41, 120);
            add_message(r);
            queued += r;
        end
    endtask

    // idle between phases: all bytes taken, all frames out, then some settle time
    task automatic wait_drained();
        while (bytes_pending.size() != 0 || s_axis_tvalid || frames_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset register values: single-byte extremes, short, exactly
        // one full frame, and one byte past a full frame
        add_byte(8'h00, 1'b1, 7'h00);
        add_byte(8'hFF, 1'b1, 7'h7F);
        msgs_queued += 2;
        add_message(5);
        add_message(8);
        add_message(9);
        wait_drained();

        // all-zero source and function registers
        write_reg(CFG_SOURCE_ID, 8'h00);
        write_reg(CFG_FUNCTION_CODE, 8'h00);
        settings++;
        add_messages(450);
        wait_drained();

        // all-ones, upper bits of the function write must be dropped
        write_reg(CFG_SOURCE_ID, 8'hFF);
        write_reg(CFG_FUNCTION_CODE, 8'hFF);
        settings++;
        add_messages(450);
        wait_drained();

        // random registers, long output hold while bytes keep coming
        write_reg(CFG_SOURCE_ID, 8'($urandom_range(0, 255)));
        write_reg(CFG_FUNCTION_CODE, 8'($urandom_range(0, 255)));
        settings++;
        add_messages(450);
        hold_start = 1'b1;
        wait_drained();

        // last part at full rate, no idling either side
        write_reg(CFG_FUNCTION_CODE, 8'($urandom_range(0, 15)));
        write_reg(CFG_SOURCE_ID, 8'($urandom_range(0, 255)));
        settings++;
        quiet = 1'b1;
        add_messages(450);
        wait_drained();

        $display("covered %0d bytes in %0d messages, %0d frames checked",
                 bytes_taken, msgs_queued, frames_seen);
        $display("%0d register settings and a %0d-cycle output hold included",
                 settings, HOLD_LEN);
        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
sv/cms_pkg.sv
sv/cms_front.sv
sv/cms_queue.sv
sv/cms_back.sv
sv/can_message_segmenter_unit.sv
bench/tb_can_message_segmenter_unit.sv
